// File: design/hpt_pkg.sv
// Shared constants and types for the homogeneous point transform core.
// No dependencies; imported by homogeneous_point_transform_core.
package hpt_pkg;

    localparam int NUM_CFG     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COORD_W     = 32;
    localparam int NUM_LANES   = 3;
    localparam int NUM_ROWS    = 4;
    localparam int AXIS_DATA_W = NUM_LANES * COORD_W;

    // Matrix row that carries the homogeneous w term.
    localparam int W_ROW = 3;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    typedef struct packed {
        logic point;   // point mode (divide by w)
        logic w_zero;  // rounded w was zero
        logic unity;   // rounded w was exactly one
    } t_item_ctl;

endpackage

// File: design/homogeneous_point_transform_core.sv
// Pipelined 4x4 homogeneous transform of Q fixed-point 3D points and vectors.
// Depends on hpt_pkg.
//
// Usage:
//   Configuration: i_cfg_we writes i_cfg_data into matrix register i_cfg_index
//   (two elements per 64-bit register, low element in the low half). Write only
//   while no item is in flight.
//   Input channel s_axis_*: tdata carries x, y, z (32 bits each, x lowest),
//   tuser carries the mode bit (0 point with w divide, 1 direction vector).
//   Output channel m_axis_*: tdata carries the transformed x, y, z, tuser the
//   saturated flag (bit 0) and the zero-w flag (bit 1).
//   QB = max(WORD_BITS, FRAC_BITS) + 1 is the number of quotient bits. The
//   long divider is one restoring step per stage, so one item per cycle is
//   taken as long as the output is not stalled by m_axis_tready.
//   Every stage holds a valid bit and advances when the stage after it is
//   empty or advancing, so bubbles are squeezed out while the output waits.
//   A stalled receiver fills the pipeline and then drops s_axis_tready; no
//   item is lost or repeated.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   identity matrix.
module homogeneous_point_transform_core
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_index,
    input  t_cfg_word              i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [AXIS_DATA_W-1:0] s_axis_tdata,   // in_x, in_y, in_z
    input  logic                   s_axis_tuser,   // func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [AXIS_DATA_W-1:0] m_axis_tdata,   // out_x, out_y, out_z
    output logic [1:0]             m_axis_tuser    // saturated, w_zero
);

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int PW    = 2 * W;
    localparam int ACC_W = ((PW > W + F) ? PW : W + F) + 3;
    localparam int RW    = ACC_W - F;
    localparam int QB    = ((W > F) ? W : F) + 1;
    localparam int DW    = RW + QB + F + 1;
    localparam int VW    = ((RW > QB) ? RW : QB) + 2;
    localparam int LIMQ  = (W - 1 >= F) ? (1 << (W - 1 - F)) : 0;
    localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(1) << F;
    localparam logic [CFG_DATA_W-1:0] ONE_HI = CFG_DATA_W'(1) << (F + 32);
    localparam logic signed [VW-1:0] SAT_MAX = (VW'(1) <<< (W - 1)) - VW'(1);
    localparam logic signed [VW-1:0] SAT_MIN = -SAT_MAX - VW'(1);
    localparam logic signed [VW-1:0] BIG     = VW'(1) <<< W;

    // Configuration registers.
    t_cfg_word r_cfg [NUM_CFG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                if (i == 0 || i == 5) begin
                    r_cfg[i] <= ONE_LO;
                end else if (i == 2 || i == 7) begin
                    r_cfg[i] <= ONE_HI;
                end else begin
                    r_cfg[i] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    logic signed [W-1:0] mat [NUM_ROWS][4];
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < 4; c++) begin
                mat[r][c] = r_cfg[r * 2 + c / 2][(c % 2) * 32 +: W];
            end
        end
    end

    // Stage enables, chained back from the output register.
    logic en_a, en_b, en_c, en_o;
    logic en_d [QB];

    // Stage A: products.
    logic                 r_a_v, r_a_pt;
    logic signed [PW-1:0] r_a_p [NUM_ROWS][NUM_LANES];
    // Stage B: rounded rows.
    logic                 r_b_v, r_b_pt;
    logic signed [RW-1:0] r_b_r [NUM_ROWS];
    // Stage C: magnitudes and flags.
    logic                 r_c_v;
    t_item_ctl            r_c_ctl;
    logic [RW-1:0]        r_c_ad;
    logic signed [RW-1:0] r_c_r   [NUM_LANES];
    logic [DW-1:0]        r_c_rem [NUM_LANES];
    logic                 r_c_neg [NUM_LANES];
    logic                 r_c_ovf [NUM_LANES];
    // Divider stages.
    logic                 r_d_v   [QB];
    t_item_ctl            r_d_ctl [QB];
    logic [RW-1:0]        r_d_ad  [QB];
    logic signed [RW-1:0] r_d_r   [QB][NUM_LANES];
    logic [DW-1:0]        r_d_rem [QB][NUM_LANES];
    logic [QB-1:0]        r_d_q   [QB][NUM_LANES];
    logic                 r_d_neg [QB][NUM_LANES];
    logic                 r_d_ovf [QB][NUM_LANES];
    logic [DW-1:0]        n_d_rem [QB][NUM_LANES];
    logic [QB-1:0]        n_d_q   [QB][NUM_LANES];
    // Output register.
    logic                 r_o_v;
    logic [COORD_W-1:0]   r_o_x [NUM_LANES];
    logic                 r_o_sat, r_o_wz;
    logic [COORD_W-1:0]   n_o_x [NUM_LANES];
    logic                 n_o_sat;

    always_comb begin
        en_o = !r_o_v || m_axis_tready;
        en_d[QB-1] = !r_d_v[QB-1] || en_o;
        for (int k = QB - 2; k >= 0; k--) begin
            en_d[k] = !r_d_v[k] || en_d[k+1];
        end
        en_c = !r_c_v || en_d[0];
        en_b = !r_b_v || en_c;
        en_a = !r_a_v || en_b;
    end

    assign s_axis_tready = en_a;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_o_v <= 1'b0;
            for (int k = 0; k < QB; k++) begin
                r_d_v[k] <= 1'b0;
            end
        end else begin
            if (en_a) begin
                r_a_v <= s_axis_tvalid;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
            if (en_c) begin
                r_c_v <= r_b_v;
            end
            if (en_d[0]) begin
                r_d_v[0] <= r_c_v;
            end
            for (int k = 1; k < QB; k++) begin
                if (en_d[k]) begin
                    r_d_v[k] <= r_d_v[k-1];
                end
            end
            if (en_o) begin
                r_o_v <= r_d_v[QB-1];
            end
        end
    end

    // Stage A: twelve products.
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_pt <= !s_axis_tuser;
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_LANES; c++) begin
                    r_a_p[r][c] <= PW'(mat[r][c]) *
                                   PW'($signed(s_axis_tdata[c * COORD_W +: W]));
                end
            end
        end
    end

    // Stage B: sum, translation (point mode only) and round half up.
    logic signed [ACC_W-1:0] sum_b [NUM_ROWS];
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            sum_b[r] = ACC_W'(r_a_p[r][0]) + ACC_W'(r_a_p[r][1]) + ACC_W'(r_a_p[r][2])
                     + (ACC_W'(1) <<< (F - 1));
            if (r_a_pt) begin
                sum_b[r] = sum_b[r] + (ACC_W'(mat[r][3]) <<< F);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_pt <= r_a_pt;
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_b_r[r] <= RW'(sum_b[r] >>> F);
            end
        end
    end

    // Stage C: magnitudes, signs and the quotient overflow test.
    logic [RW-1:0] ad_c;
    logic [RW-1:0] an_c [NUM_LANES];
    always_comb begin
        ad_c = r_b_r[W_ROW][RW-1] ? RW'(-r_b_r[W_ROW]) : RW'(r_b_r[W_ROW]);
        for (int l = 0; l < NUM_LANES; l++) begin
            an_c[l] = r_b_r[l][RW-1] ? RW'(-r_b_r[l]) : RW'(r_b_r[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_ctl.point  <= r_b_pt;
            r_c_ctl.w_zero <= (r_b_r[W_ROW] == '0);
            r_c_ctl.unity  <= (r_b_r[W_ROW] == (RW'(1) <<< F));
            r_c_ad         <= ad_c;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_c_r[l]   <= r_b_r[l];
                r_c_rem[l] <= DW'(an_c[l]) << (F + 1);
                r_c_neg[l] <= r_b_r[l][RW-1] ^ r_b_r[W_ROW][RW-1];
                r_c_ovf[l] <= DW'(an_c[l]) >= DW'(ad_c) * DW'(LIMQ + 1);
            end
        end
    end

    // Divider: stage k resolves quotient bit QB-1-k of each lane.
    logic [DW-1:0] src_rem;
    logic [QB-1:0] src_q;
    logic [DW-1:0] cmp_d;
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                if (k == 0) begin
                    src_rem = r_c_rem[l];
                    src_q   = '0;
                    cmp_d   = DW'(r_c_ad) << (QB - 1 - k);
                end else begin
                    src_rem = r_d_rem[k-1][l];
                    src_q   = r_d_q[k-1][l];
                    cmp_d   = DW'(r_d_ad[k-1]) << (QB - 1 - k);
                end
                n_d_rem[k][l] = src_rem;
                n_d_q[k][l]   = src_q;
                if (src_rem >= cmp_d) begin
                    n_d_rem[k][l]           = src_rem - cmp_d;
                    n_d_q[k][l][QB - 1 - k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d[0]) begin
            r_d_ctl[0] <= r_c_ctl;
            r_d_ad[0]  <= r_c_ad;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_d_r[0][l]   <= r_c_r[l];
                r_d_neg[0][l] <= r_c_neg[l];
                r_d_ovf[0][l] <= r_c_ovf[l];
                r_d_rem[0][l] <= n_d_rem[0][l];
                r_d_q[0][l]   <= n_d_q[0][l];
            end
        end
        for (int k = 1; k < QB; k++) begin
            if (en_d[k]) begin
                r_d_ctl[k] <= r_d_ctl[k-1];
                r_d_ad[k]  <= r_d_ad[k-1];
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_d_r[k][l]   <= r_d_r[k-1][l];
                    r_d_neg[k][l] <= r_d_neg[k-1][l];
                    r_d_ovf[k][l] <= r_d_ovf[k-1][l];
                    r_d_rem[k][l] <= n_d_rem[k][l];
                    r_d_q[k][l]   <= n_d_q[k][l];
                end
            end
        end
    end

    // Output stage: pick the result per mode, then saturate to the word range.
    t_item_ctl              ctl_o;
    logic [VW-1:0]          mag_o;
    logic signed [VW-1:0]   val_o;
    logic signed [VW-1:0]   rv_o;
    always_comb begin
        ctl_o   = r_d_ctl[QB-1];
        n_o_sat = ctl_o.point && ctl_o.w_zero;
        for (int l = 0; l < NUM_LANES; l++) begin
            rv_o  = VW'(r_d_r[QB-1][l]);
            mag_o = r_d_ovf[QB-1][l] ? VW'(BIG)
                                     : (VW'(r_d_q[QB-1][l]) + VW'(1)) >> 1;
            if (ctl_o.point && ctl_o.w_zero) begin
                if (rv_o > 0) begin
                    val_o = BIG;
                end else if (rv_o < 0) begin
                    val_o = -BIG;
                end else begin
                    val_o = '0;
                end
            end else if (ctl_o.point && !ctl_o.unity) begin
                val_o = r_d_neg[QB-1][l] ? -$signed(mag_o) : $signed(mag_o);
            end else begin
                val_o = rv_o;
            end
            if (val_o > SAT_MAX) begin
                val_o   = SAT_MAX;
                n_o_sat = 1'b1;
            end else if (val_o < SAT_MIN) begin
                val_o   = SAT_MIN;
                n_o_sat = 1'b1;
            end
            n_o_x[l] = COORD_W'($signed(val_o[W-1:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_sat <= n_o_sat;
            r_o_wz  <= ctl_o.point && ctl_o.w_zero;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_o_x[l] <= n_o_x[l];
            end
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {r_o_x[2], r_o_x[1], r_o_x[0]};
    assign m_axis_tuser  = {r_o_wz, r_o_sat};

endmodule
